// ===== hdl/btds_pkg.sv =====
// Package for the backoff timer: command codes, phase and sequencer types.
`timescale 1ns / 1ps
package btds_pkg;

  localparam logic [2:0] KIND_TICK   = 3'd0;
  localparam logic [2:0] KIND_START  = 3'd1;
  localparam logic [2:0] KIND_PAUSE  = 3'd2;
  localparam logic [2:0] KIND_RESUME = 3'd3;
  localparam logic [2:0] KIND_STOP   = 3'd4;

  localparam int unsigned RND_W    = 31;
  localparam int unsigned WIN_W    = 11;
  localparam int unsigned TICK_W   = 16;
  localparam int unsigned SLOT_W   = 10;
  localparam int unsigned DIVCNT_W = 5;

  localparam logic [DIVCNT_W-1:0] DIV_LAST  = DIVCNT_W'(RND_W - 1);
  localparam logic [TICK_W-1:0]   SLOT_RST  = 16'd20;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DIFS,
    PH_COUNT,
    PH_FROZEN
  } phase_e;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_DIV,
    SQ_FIN
  } seq_e;

endpackage

// ===== hdl/backoff_timer_difs_slot.sv =====
// Backoff counter with DIFS wait and slot countdown, one result per request.
`timescale 1ns / 1ps
// Tick, pause, resume, stop and any rejected command register their result on
// acceptance. A start accepted in the idle phase reduces its random value
// modulo the window in a restoring remainder unit that retires one dividend
// bit per cycle and registers its result after the last bit. The block takes
// one request at a time; a new request is accepted once the sequencer is free,
// and each result is registered once the output register is empty or being
// read. slot_ticks may be written only when no request is outstanding.
module backoff_timer_difs_slot
  import btds_pkg::*;
#(
  parameter int unsigned MAX_WINDOW = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [TICK_W-1:0]   cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [2:0]          kind_i,
  input  logic [WIN_W-1:0]    window_i,
  input  logic                medium_idle_i,
  input  logic [RND_W-1:0]    random_value_i,
  input  logic [TICK_W-1:0]   difs_ticks_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                expired_o,
  output logic                running_o,
  output logic                frozen_o,
  output logic [SLOT_W-1:0]   slots_left_o,
  output logic                bad_command_o
);

  seq_e                seq_q, seq_d;
  phase_e              phase_q, phase_d;
  logic [TICK_W-1:0]   slot_ticks_q;
  logic [TICK_W-1:0]   difs_left_q, difs_left_d;
  logic [TICK_W-1:0]   slot_cnt_q, slot_cnt_d;
  logic [SLOT_W-1:0]   slots_q, slots_d;

  logic [RND_W-1:0]    dvd_q, dvd_d;
  logic [WIN_W-1:0]    rem_q, rem_d;
  logic [WIN_W-1:0]    win_q, win_d;
  logic [DIVCNT_W-1:0] div_cnt_q, div_cnt_d;
  logic                idle_q, idle_d;
  logic [TICK_W-1:0]   difs_in_q, difs_in_d;

  logic                out_valid_q, out_valid_d;
  logic                out_expired_q, out_expired_d;
  logic                out_running_q, out_running_d;
  logic                out_frozen_q, out_frozen_d;
  logic [SLOT_W-1:0]   out_slots_q, out_slots_d;
  logic                out_bad_q, out_bad_d;

  logic                in_fire;
  logic                load_out, expire, bad;
  logic [TICK_W-1:0]   slot_len;
  logic [TICK_W-1:0]   difs_dec, cnt_inc;
  logic [SLOT_W-1:0]   slots_dec;
  logic [WIN_W-1:0]    win_eff;
  logic [WIN_W:0]      trial;
  logic [WIN_W:0]      trial_diff;

  assign in_ready_o = (seq_q == SQ_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;

  assign slot_len  = (slot_ticks_q == '0) ? TICK_W'(1) : slot_ticks_q;
  assign difs_dec  = difs_left_q - TICK_W'(1);
  assign cnt_inc   = slot_cnt_q + TICK_W'(1);
  assign slots_dec = slots_q - SLOT_W'(1);

  always_comb begin
    win_eff = (window_i == '0) ? WIN_W'(1) : window_i;
    if (32'(window_i) > MAX_WINDOW) begin
      win_eff = WIN_W'(MAX_WINDOW);
    end
  end

  // remainder step: shift in one dividend bit, subtract if it fits
  assign trial      = {rem_q, dvd_q[RND_W-1]};
  assign trial_diff = trial - {1'b0, win_q};

  always_comb begin
    seq_d         = seq_q;
    phase_d       = phase_q;
    difs_left_d   = difs_left_q;
    slot_cnt_d    = slot_cnt_q;
    slots_d       = slots_q;
    dvd_d         = dvd_q;
    rem_d         = rem_q;
    win_d         = win_q;
    div_cnt_d     = div_cnt_q;
    idle_d        = idle_q;
    difs_in_d     = difs_in_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    out_expired_d = out_expired_q;
    out_running_d = out_running_q;
    out_frozen_d  = out_frozen_q;
    out_slots_d   = out_slots_q;
    out_bad_d     = out_bad_q;
    load_out      = 1'b0;
    expire        = 1'b0;
    bad           = 1'b0;

    unique case (seq_q)
      SQ_IDLE: begin
        if (in_fire) begin
          load_out = 1'b1;
          unique case (kind_i)
            KIND_TICK: begin
              if (phase_q == PH_DIFS) begin
                difs_left_d = difs_dec;
                if (difs_dec == '0) begin
                  phase_d = PH_COUNT;
                  expire  = (slots_q == '0);
                end
              end else if (phase_q == PH_COUNT) begin
                if (slots_q == '0) begin
                  expire = 1'b1;
                end else if (cnt_inc >= slot_len) begin
                  slot_cnt_d = '0;
                  slots_d    = slots_dec;
                  expire     = (slots_dec == '0);
                end else begin
                  slot_cnt_d = cnt_inc;
                end
              end
              if (expire) begin
                phase_d     = PH_IDLE;
                difs_left_d = '0;
                slot_cnt_d  = '0;
                slots_d     = '0;
              end
            end
            KIND_START: begin
              if (phase_q != PH_IDLE) begin
                bad = 1'b1;
              end else begin
                load_out  = 1'b0;
                seq_d     = SQ_DIV;
                dvd_d     = random_value_i;
                rem_d     = '0;
                win_d     = win_eff;
                div_cnt_d = '0;
                idle_d    = medium_idle_i;
                difs_in_d = difs_ticks_i;
              end
            end
            KIND_PAUSE: begin
              if (phase_q != PH_DIFS && phase_q != PH_COUNT) begin
                bad = 1'b1;
              end else begin
                phase_d     = PH_FROZEN;
                difs_left_d = '0;
                slot_cnt_d  = '0;
              end
            end
            KIND_RESUME: begin
              if (phase_q != PH_FROZEN) begin
                bad = 1'b1;
              end else begin
                difs_left_d = difs_ticks_i;
                slot_cnt_d  = '0;
                phase_d     = (difs_ticks_i != '0) ? PH_DIFS : PH_COUNT;
              end
            end
            KIND_STOP: begin
              if (phase_q == PH_IDLE) begin
                bad = 1'b1;
              end else begin
                phase_d     = PH_IDLE;
                difs_left_d = '0;
                slot_cnt_d  = '0;
                slots_d     = '0;
              end
            end
            default: bad = 1'b1;
          endcase
        end
      end
      SQ_DIV: begin
        rem_d     = trial[WIN_W] || (trial[WIN_W-1:0] >= win_q) ?
                    trial_diff[WIN_W-1:0] : trial[WIN_W-1:0];
        dvd_d     = {dvd_q[RND_W-2:0], 1'b0};
        div_cnt_d = div_cnt_q + DIVCNT_W'(1);
        if (div_cnt_q == DIV_LAST) begin
          seq_d = SQ_FIN;
        end
      end
      SQ_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          seq_d    = SQ_IDLE;
          slots_d  = rem_q[WIN_W-1] ? '1 : rem_q[SLOT_W-1:0];
          slot_cnt_d = '0;
          if (!idle_q) begin
            difs_left_d = '0;
            phase_d     = PH_FROZEN;
          end else begin
            difs_left_d = difs_in_q;
            phase_d     = (difs_in_q != '0) ? PH_DIFS : PH_COUNT;
          end
        end
      end
      default: seq_d = SQ_IDLE;
    endcase

    if (load_out) begin
      out_valid_d   = 1'b1;
      out_expired_d = expire;
      out_running_d = (phase_d != PH_IDLE);
      out_frozen_d  = (phase_d == PH_FROZEN);
      out_slots_d   = slots_d;
      out_bad_d     = bad;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q        <= SQ_IDLE;
      phase_q      <= PH_IDLE;
      slot_ticks_q <= SLOT_RST;
      difs_left_q  <= '0;
      slot_cnt_q   <= '0;
      slots_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      seq_q       <= seq_d;
      phase_q     <= phase_d;
      difs_left_q <= difs_left_d;
      slot_cnt_q  <= slot_cnt_d;
      slots_q     <= slots_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        slot_ticks_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q         <= dvd_d;
    rem_q         <= rem_d;
    win_q         <= win_d;
    div_cnt_q     <= div_cnt_d;
    idle_q        <= idle_d;
    difs_in_q     <= difs_in_d;
    out_expired_q <= out_expired_d;
    out_running_q <= out_running_d;
    out_frozen_q  <= out_frozen_d;
    out_slots_q   <= out_slots_d;
    out_bad_q     <= out_bad_d;
  end

  assign out_valid_o   = out_valid_q;
  assign expired_o     = out_expired_q;
  assign running_o     = out_running_q;
  assign frozen_o      = out_frozen_q;
  assign slots_left_o  = out_slots_q;
  assign bad_command_o = out_bad_q;

  a_expire_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && expired_o |-> !running_o && !frozen_o && slots_left_o == '0)
    else $error("expiry result not cleared");

  a_frozen_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frozen_o |-> running_o)
    else $error("frozen without running");

  a_div_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_q == SQ_DIV |=> seq_q == SQ_DIV || seq_q == SQ_FIN)
    else $error("remainder sequence broken");

  a_difs_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DIFS |-> difs_left_q != '0)
    else $error("DIFS phase with nothing left");

  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_q != SQ_IDLE |-> !in_ready_o)
    else $error("request taken while remainder unit busy");

endmodule

// ===== dv/backoff_timer_difs_slot_tb.sv =====
// Testbench for the backoff timer: directed table, then random requests checked by a predictor.
`timescale 1ns / 1ps
module backoff_timer_difs_slot_tb
  import btds_pkg::*;
();

  localparam int unsigned MAX_WIN     = 1024;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RX_HOLD     = 400;
  localparam logic [2:0]  KIND_RSV5   = 3'd5;
  localparam logic [2:0]  KIND_RSV6   = 3'd6;
  localparam logic [2:0]  KIND_RSV7   = 3'd7;

  typedef struct packed {
    logic [2:0]        kind;
    logic [WIN_W-1:0]  window;
    logic              medium_idle;
    logic [RND_W-1:0]  rnd;
    logic [TICK_W-1:0] difs;
  } req_t;

  typedef struct packed {
    logic              expired;
    logic              running;
    logic              frozen;
    logic [SLOT_W-1:0] slots;
    logic              bad;
  } status_t;

  typedef struct {
    req_t    rq;
    bit      typed;
    status_t want;
  } row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [TICK_W-1:0]   cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [2:0]          kind_i = KIND_TICK;
  logic [WIN_W-1:0]    window_i = '0;
  logic                medium_idle_i = 1'b0;
  logic [RND_W-1:0]    random_value_i = '0;
  logic [TICK_W-1:0]   difs_ticks_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                expired_o;
  logic                running_o;
  logic                frozen_o;
  logic [SLOT_W-1:0]   slots_left_o;
  logic                bad_command_o;

  // predictor state
  phase_e            bo_phase;
  logic [TICK_W-1:0] difs_left;
  int unsigned       slot_cnt;
  logic [SLOT_W-1:0] slots_rem;
  logic [TICK_W-1:0] slot_len;

  status_t     status_q[$];
  row_t        plan[$];
  int unsigned n_mismatch = 0;
  int unsigned n_sent = 0;
  bit          gaps_on = 1'b1;
  bit          rx_hold_req = 1'b0;

  backoff_timer_difs_slot #(
    .MAX_WINDOW(MAX_WIN)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .window_i       (window_i),
    .medium_idle_i  (medium_idle_i),
    .random_value_i (random_value_i),
    .difs_ticks_i   (difs_ticks_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .expired_o      (expired_o),
    .running_o      (running_o),
    .frozen_o       (frozen_o),
    .slots_left_o   (slots_left_o),
    .bad_command_o  (bad_command_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic void clear_timer();
    bo_phase  = PH_IDLE;
    difs_left = '0;
    slot_cnt  = 0;
    slots_rem = '0;
  endfunction

  function automatic void freeze_timer();
    difs_left = '0;
    slot_cnt  = 0;
    bo_phase  = PH_FROZEN;
  endfunction

  function automatic void arm_difs(logic [TICK_W-1:0] d);
    difs_left = d;
    slot_cnt  = 0;
    bo_phase  = (d != 0) ? PH_DIFS : PH_COUNT;
  endfunction

  function automatic status_t predict_status(req_t rq);
    status_t     st;
    int unsigned w;
    int unsigned s;
    int unsigned len;
    st  = '0;
    len = (slot_len == 0) ? 1 : slot_len;
    case (rq.kind)
      KIND_TICK: begin
        if (bo_phase == PH_DIFS) begin
          difs_left = difs_left - 1'b1;
          if (difs_left == 0) begin
            bo_phase   = PH_COUNT;
            st.expired = (slots_rem == 0);
          end
        end else if (bo_phase == PH_COUNT) begin
          if (slots_rem == 0) begin
            st.expired = 1'b1;
          end else begin
            slot_cnt++;
            if (slot_cnt >= len) begin
              slot_cnt   = 0;
              slots_rem  = slots_rem - 1'b1;
              st.expired = (slots_rem == 0);
            end
          end
        end
        if (st.expired) clear_timer();
      end
      KIND_START: begin
        if (bo_phase != PH_IDLE) begin
          st.bad = 1'b1;
        end else begin
          w = rq.window;
          if (w == 0) w = 1;
          if (w > MAX_WIN) w = MAX_WIN;
          s = rq.rnd % w;
          if (s > 1023) s = 1023;
          slots_rem = s[SLOT_W-1:0];
          if (!rq.medium_idle) freeze_timer();
          else arm_difs(rq.difs);
        end
      end
      KIND_PAUSE: begin
        if (bo_phase != PH_DIFS && bo_phase != PH_COUNT) st.bad = 1'b1;
        else freeze_timer();
      end
      KIND_RESUME: begin
        if (bo_phase != PH_FROZEN) st.bad = 1'b1;
        else arm_difs(rq.difs);
      end
      KIND_STOP: begin
        if (bo_phase == PH_IDLE) st.bad = 1'b1;
        else clear_timer();
      end
      default: st.bad = 1'b1;
    endcase
    st.running = (bo_phase != PH_IDLE);
    st.frozen  = (bo_phase == PH_FROZEN);
    st.slots   = slots_rem;
    return st;
  endfunction

  function automatic status_t mk_status(bit e, bit r, bit f, int unsigned s, bit b);
    status_t st;
    st.expired = e;
    st.running = r;
    st.frozen  = f;
    st.slots   = s[SLOT_W-1:0];
    st.bad     = b;
    return st;
  endfunction

  function automatic row_t mk_row(logic [2:0] kind, int unsigned win, bit idle,
                                  int unsigned rnd, int unsigned difs, bit typed,
                                  status_t want);
    row_t r;
    r.rq.kind        = kind;
    r.rq.window      = win[WIN_W-1:0];
    r.rq.medium_idle = idle;
    r.rq.rnd         = rnd[RND_W-1:0];
    r.rq.difs        = difs[TICK_W-1:0];
    r.typed          = typed;
    r.want           = want;
    return r;
  endfunction

  function automatic req_t random_req(logic [2:0] kind);
    req_t rq;
    rq.kind        = kind;
    rq.window      = WIN_W'($urandom);
    rq.medium_idle = 1'($urandom);
    rq.rnd         = RND_W'($urandom);
    rq.difs        = TICK_W'($urandom);
    return rq;
  endfunction

  task automatic flag_error(input string msg);
    n_mismatch++;
    if (n_mismatch <= 10) $display("MISMATCH: %s", msg);
  endtask

  task automatic send_req(input req_t rq, input bit typed, input status_t want);
    status_t st;
    while (gaps_on && $urandom_range(99) < 28) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    kind_i         <= rq.kind;
    window_i       <= rq.window;
    medium_idle_i  <= rq.medium_idle;
    random_value_i <= rq.rnd;
    difs_ticks_i   <= rq.difs;
    do @(posedge clk_i); while (!in_ready_o);
    st = predict_status(rq);
    status_q.push_back(typed ? want : st);
    n_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (status_q.size() != 0);
  endtask

  task automatic set_slot_len(input logic [TICK_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    slot_len = v;
  endtask

  // one start followed by commands until the counter goes idle or 60 steps pass, or a burst of noise
  task automatic run_episode();
    req_t        rq;
    int unsigned pick;
    int unsigned steps;
    if ($urandom_range(99) < 10) begin
      repeat ($urandom_range(1, 6)) begin
        rq = random_req(3'($urandom_range(0, 7)));
        send_req(rq, 1'b0, '0);
      end
      return;
    end
    rq = random_req(KIND_START);
    if ($urandom_range(99) < 85) begin
      rq.window = WIN_W'($urandom_range(1, 12));
      rq.difs   = TICK_W'($urandom_range(0, 6));
    end
    rq.medium_idle = ($urandom_range(99) < 85);
    send_req(rq, 1'b0, '0);
    steps = 0;
    while (bo_phase != PH_IDLE && steps < 60) begin
      pick = $urandom_range(99);
      rq   = random_req(KIND_TICK);
      if (bo_phase == PH_FROZEN && pick < 40) begin
        rq.kind = KIND_RESUME;
        if (pick < 36) rq.difs = TICK_W'($urandom_range(0, 6));
      end else if (pick < 72) begin
        rq.kind = KIND_TICK;
      end else if (pick < 80) begin
        rq.kind = KIND_PAUSE;
      end else if (pick < 90) begin
        rq.kind = KIND_RESUME;
        if (pick < 88) rq.difs = TICK_W'($urandom_range(0, 6));
      end else if (pick < 93) begin
        rq.kind = KIND_STOP;
      end else if (pick < 96) begin
        rq.kind = KIND_START;
      end else begin
        rq.kind = 3'($urandom_range(KIND_RSV5, KIND_RSV7));
      end
      send_req(rq, 1'b0, '0);
      steps++;
    end
    if (bo_phase != PH_IDLE && $urandom_range(1) == 1) begin
      rq = random_req(KIND_STOP);
      send_req(rq, 1'b0, '0);
    end
    if ($urandom_range(99) < 8) drain();
  endtask

  // result side: check, then decide ready for the next cycle
  initial begin : result_sink
    status_t     want;
    int unsigned hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (status_q.size() == 0) begin
          flag_error($sformatf("unexpected result exp=%0b run=%0b frz=%0b slots=%0d bad=%0b",
                               expired_o, running_o, frozen_o, slots_left_o, bad_command_o));
        end else begin
          want = status_q.pop_front();
          if (expired_o !== want.expired || running_o !== want.running ||
              frozen_o !== want.frozen || slots_left_o !== want.slots ||
              bad_command_o !== want.bad)
            flag_error($sformatf(
              "expected exp=%0b run=%0b frz=%0b slots=%0d bad=%0b, got %0b %0b %0b %0d %0b",
              want.expired, want.running, want.frozen, want.slots, want.bad,
              expired_o, running_o, frozen_o, slots_left_o, bad_command_o));
        end
      end
      if (rx_hold_req) begin
        hold        = RX_HOLD;
        rx_hold_req = 1'b0;
      end
      if (hold != 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= !(gaps_on && $urandom_range(99) < 28);
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [TICK_W-1:0] v;
    int unsigned       target;
    clear_timer();
    slot_len = SLOT_RST;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset slot length of 20 ticks
    plan.push_back(mk_row(KIND_TICK,   0, 0, 0, 0, 1, mk_status(0, 0, 0, 0, 0)));
    plan.push_back(mk_row(KIND_PAUSE,  0, 0, 0, 0, 1, mk_status(0, 0, 0, 0, 1)));
    plan.push_back(mk_row(KIND_RESUME, 0, 0, 0, 0, 1, mk_status(0, 0, 0, 0, 1)));
    plan.push_back(mk_row(KIND_STOP,   0, 0, 0, 0, 1, mk_status(0, 0, 0, 0, 1)));
    plan.push_back(mk_row(KIND_RSV5,   0, 0, 0, 0, 1, mk_status(0, 0, 0, 0, 1)));
    plan.push_back(mk_row(KIND_RSV7, 2047, 1, 32'h7FFF_FFFF, 65535, 1,
                          mk_status(0, 0, 0, 0, 1)));
    // zero window acts as one: no slots, expires on the next tick
    plan.push_back(mk_row(KIND_START, 0, 1, 32'h7FFF_FFFF, 0, 1, mk_status(0, 1, 0, 0, 0)));
    plan.push_back(mk_row(KIND_TICK,  0, 0, 0, 0, 1, mk_status(1, 0, 0, 0, 0)));
    // oversized window clamps to the max, busy medium starts frozen
    plan.push_back(mk_row(KIND_START, 2047, 0, 32'h7FFF_FFFF, 0, 1,
                          mk_status(0, 1, 1, 1023, 0)));
    plan.push_back(mk_row(KIND_START, 5, 1, 3, 0, 1, mk_status(0, 1, 1, 1023, 1)));
    plan.push_back(mk_row(KIND_TICK,  0, 0, 0, 0, 1, mk_status(0, 1, 1, 1023, 0)));
    plan.push_back(mk_row(KIND_PAUSE, 0, 0, 0, 0, 1, mk_status(0, 1, 1, 1023, 1)));
    plan.push_back(mk_row(KIND_RESUME, 0, 0, 0, 65535, 1, mk_status(0, 1, 0, 1023, 0)));
    plan.push_back(mk_row(KIND_RESUME, 0, 0, 0, 0, 1, mk_status(0, 1, 0, 1023, 1)));
    plan.push_back(mk_row(KIND_TICK,  0, 0, 0, 0, 1, mk_status(0, 1, 0, 1023, 0)));
    plan.push_back(mk_row(KIND_PAUSE, 0, 0, 0, 0, 1, mk_status(0, 1, 1, 1023, 0)));
    plan.push_back(mk_row(KIND_STOP,  0, 0, 0, 0, 1, mk_status(0, 0, 0, 0, 0)));
    // DIFS with no slots expires when the DIFS ends
    plan.push_back(mk_row(KIND_START, 1, 1, 123, 1, 1, mk_status(0, 1, 0, 0, 0)));
    plan.push_back(mk_row(KIND_TICK,  0, 0, 0, 0, 1, mk_status(1, 0, 0, 0, 0)));
    plan.push_back(mk_row(KIND_START, 1024, 1, 1025, 2, 0, '0));
    plan.push_back(mk_row(KIND_TICK,  0, 0, 0, 0, 0, '0));
    plan.push_back(mk_row(KIND_TICK,  0, 0, 0, 0, 0, '0));
    plan.push_back(mk_row(KIND_RSV6,  0, 0, 0, 0, 0, '0));
    plan.push_back(mk_row(KIND_TICK,  0, 0, 0, 0, 0, '0));
    plan.push_back(mk_row(KIND_PAUSE, 0, 0, 0, 0, 0, '0));
    foreach (plan[i]) send_req(plan[i].rq, plan[i].typed, plan[i].want);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: v = 16'd1;
        1: v = 16'd0;
        2: v = 16'd3;
        3: v = 16'hFFFF;
        4: v = 16'd2;
        default: v = TICK_W'($urandom_range(1, 6));
      endcase
      set_slot_len(v);
      gaps_on = (ph != 1);
      if (ph == 2) rx_hold_req = 1'b1;
      target = n_sent + 100;
      while (n_sent < target) run_episode();
      drain();
    end

    repeat (40) @(posedge clk_i);
    if (status_q.size() != 0)
      flag_error($sformatf("%0d results never arrived", status_q.size()));
    if (n_mismatch == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
